// ===== design/sitda_pkg.sv =====
// Shared types and constants of the signed integer to decimal text converter.
// Used by the front, queue, back, top level and checker files; no dependencies.
package sitda_pkg;

  localparam int VALUE_W       = 32;
  localparam int DIGITS        = 10;
  localparam int DIGIT_W       = 4;
  localparam int LEN_W         = 4;
  localparam int CHAR_W        = 8;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS);
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // One converted value, ready to be spelled out.
  typedef struct packed {
    logic                            negative;
    logic [LEN_W-1:0]                ndig;
    logic [LEN_W-1:0]                text_length;
    logic [DIGITS-1:0][DIGIT_W-1:0]  digits;
  } entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

// ===== design/signed_int_to_decimal_ascii_top.sv =====
// Signed 32-bit integer to decimal text. The text of each item follows one
// character a cycle. The front converts an item in 8 conversion steps of four
// bits and pushes it to the queue before it accepts the next; a full queue
// holds it in the push state. The result side cannot stall. Synchronous reset
// clears the state machines, the queue pointers and count, and the strobe.
module signed_int_to_decimal_ascii_top #(
  parameter int QUEUE_DEPTH = sitda_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value,
  output logic                                 busy,
  output logic                                 strobe,
  output logic [sitda_pkg::CHAR_W-1:0]         character,
  output logic [sitda_pkg::LEN_W-1:0]          text_length,
  output logic                                 last
);
  import sitda_pkg::*;

  entry_t    push_entry;
  entry_t    head_entry;
  q_status_t q_status;
  logic      push;
  logic      pop;

  sitda_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .value    (value),
    .busy     (busy),
    .q_status (q_status),
    .push     (push),
    .entry    (push_entry)
  );

  sitda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_entry),
    .pop     (pop),
    .rd_data (head_entry),
    .status  (q_status)
  );

  sitda_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .q_data      (head_entry),
    .pop         (pop),
    .strobe      (strobe),
    .character   (character),
    .text_length (text_length),
    .last        (last)
  );

endmodule

// ===== design/sitda_front.sv =====
// Front part: accepts one value, takes its magnitude and converts it to BCD
// by shift-and-add-3, four bits a cycle. Depends on sitda_pkg.
module sitda_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value,
  output logic                                busy,
  input  sitda_pkg::q_status_t                q_status,
  output logic                                push,
  output sitda_pkg::entry_t                   entry
);
  import sitda_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t                          state;
  logic [STEP_W-1:0]               step_cnt;
  logic                            negative;
  logic [VALUE_W-1:0]              mag;
  logic [DIGITS-1:0][DIGIT_W-1:0]  bcd;

  logic [VALUE_W-1:0]              raw;
  logic [VALUE_W-1:0]              mag_next;
  logic [DIGITS-1:0][DIGIT_W-1:0]  bcd_next;
  logic [LEN_W-1:0]                ndig;

  assign raw = value;

  // Four shift-and-add-3 steps per cycle; the digits within a step are independent.
  always_comb begin
    bcd_next = bcd;
    mag_next = mag;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_next[d] >= 4'd5) begin
          bcd_next[d] = bcd_next[d] + 4'd3;
        end
      end
      {bcd_next, mag_next} = {bcd_next, mag_next} << 1;
    end
  end

  // Number of significant digits; zero still spells one digit.
  always_comb begin
    ndig = LEN_W'(1);
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[d] != '0) begin
        ndig = LEN_W'(d + 1);
      end
    end
  end

  assign entry.negative    = negative;
  assign entry.ndig        = ndig;
  assign entry.text_length = ndig + LEN_W'(negative);
  assign entry.digits      = bcd;

  assign busy = (state != ST_IDLE);
  assign push = (state == ST_PUSH) && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            negative <= raw[VALUE_W-1];
            // Unsigned negation also covers the most negative value.
            mag      <= raw[VALUE_W-1] ? ('0 - raw) : raw;
            bcd      <= '0;
            step_cnt <= '0;
            state    <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd      <= bcd_next;
          mag      <= mag_next;
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_W'(CONV_STEPS - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_status.full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/sitda_queue.sv =====
// Short queue of converted items between the front and the back part.
// Depends on sitda_pkg for the entry and status types.
module sitda_queue #(
  parameter int DEPTH = sitda_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sitda_pkg::entry_t    wr_data,
  input  logic                 pop,
  output sitda_pkg::entry_t    rd_data,
  output sitda_pkg::q_status_t status
);
  import sitda_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign status.full      = (count == CNT_W'(DEPTH));
  assign status.not_empty = (count != '0);
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign rd_data          = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/sitda_back.sv =====
// Back part: takes converted items from the queue and emits their text,
// one character a cycle, through registered outputs. Depends on sitda_pkg.
module sitda_back (
  input  logic                           clk,
  input  logic                           rst,
  input  sitda_pkg::q_status_t           q_status,
  input  sitda_pkg::entry_t              q_data,
  output logic                           pop,
  output logic                           strobe,
  output logic [sitda_pkg::CHAR_W-1:0]   character,
  output logic [sitda_pkg::LEN_W-1:0]    text_length,
  output logic                           last
);
  import sitda_pkg::*;

  logic               active;
  entry_t             cur;
  logic [LEN_W-1:0]   pos;

  logic               last_c;
  logic               is_minus;
  logic [LEN_W-1:0]   digit_pos;
  logic [LEN_W-1:0]   idx;
  logic [DIGIT_W-1:0] digit;
  logic [CHAR_W-1:0]  char_c;
  logic               load;

  assign last_c    = (pos == cur.text_length - 1'b1);
  assign is_minus  = cur.negative && (pos == '0);
  assign digit_pos = pos - LEN_W'(cur.negative);
  // Most significant digit first: position zero of the digits maps to the top one.
  assign idx       = cur.ndig - 1'b1 - digit_pos;
  assign digit     = cur.digits[idx];
  assign char_c    = is_minus ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(digit));
  assign load      = (!active || last_c) && q_status.not_empty;
  assign pop       = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (!active || last_c) begin
        active <= q_status.not_empty;
      end
      if (load) begin
        cur <= q_data;
        pos <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
      character   <= char_c;
      text_length <= cur.text_length;
      last        <= last_c;
    end
  end

endmodule

// ===== design/sitda_checker.sv =====
// Port-level checks of the converter's output runs and start handshake.
// Depends on sitda_pkg; bound to signed_int_to_decimal_ascii_top below.
module sitda_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         strobe,
  input logic [sitda_pkg::CHAR_W-1:0] character,
  input logic [sitda_pkg::LEN_W-1:0]  text_length,
  input logic                         last
);
  import sitda_pkg::*;

  // A run of characters has no gaps until its last character.
  assert property (@(posedge clk) disable iff (rst) strobe && !last |=> strobe)
    else $error("gap inside a character run");

  // Every character of a run carries the same length.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> text_length == $past(text_length))
    else $error("text length changed inside a run");

  // A minus sign can only open a run.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> character != CHAR_MINUS)
    else $error("minus sign after the first character");

  // An accepted item keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("busy did not rise after an accepted item");

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_checker (.*);
